// ===== rtl/lrukv_pkg.sv =====
// shared types and constants of the lru key-value cache
package lrukv_pkg;

    // field widths of requests and responses
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CFG_W = 5;

    // packed bus widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // response field offsets within m_tdata
    localparam int M_HIT_LSB  = 0;
    localparam int M_RD_LSB   = 1;
    localparam int M_EV_LSB   = 32;
    localparam int M_EVK_LSB  = 33;
    localparam int M_USED_W   = 65;

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // request kinds
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // per-slot update command from the control logic
    typedef struct packed {
        logic load;         // insert new key/value as most recent
        logic touch;        // hit: make most recent
        logic write_value;  // with touch: overwrite the value
    } slot_op_t;

    // commands shared by all slots
    typedef struct packed {
        logic age_all;      // insertion: every valid slot gets one older
        logic age_hit;      // hit: slots newer than the hit slot get older
    } age_cmd_t;

endpackage

// ===== rtl/lrukv_slot.sv =====
// one cache slot: valid bit, key, value, recency rank and key compare
module lrukv_slot #(
    parameter int REC_W = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lrukv_pkg::slot_op_t        op,
    input  lrukv_pkg::age_cmd_t        age,
    input  logic [REC_W-1:0]           hit_rank,
    input  logic [lrukv_pkg::KEY_W-1:0] key_in,
    input  logic [lrukv_pkg::VAL_W-1:0] value_in,
    output logic                       valid,
    output logic                       match,
    output logic [lrukv_pkg::KEY_W-1:0] key,
    output logic [lrukv_pkg::VAL_W-1:0] value,
    output logic [REC_W-1:0]           rank
);

    logic                        valid_reg, valid_next;
    logic [REC_W-1:0]            rank_reg, rank_next;
    logic [lrukv_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lrukv_pkg::VAL_W-1:0] value_reg, value_next;

    // tag compare against the request in flight
    assign match = valid_reg && (key_reg == key_in);

    // next slot contents
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (op.load) begin
            valid_next = 1'b1;
            rank_next  = '0;
            key_next   = key_in;
            value_next = value_in;
        end else if (op.touch) begin
            rank_next = '0;
            if (op.write_value) begin
                value_next = value_in;
            end
        end else if (valid_reg &&
                     (age.age_all || (age.age_hit && (rank_reg < hit_rank)))) begin
            rank_next = rank_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign rank  = rank_reg;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// top level of the lru key-value cache: request register, slot array, response register
//
// Fully associative key-value cache with least-recently-used replacement.
// Requests enter on the s_ stream: s_tuser is the kind (0 get, 1 set),
// s_tdata carries the key and, for a set, the value. Each request yields
// exactly one response on the m_ stream with the hit flag, the read value,
// the eviction flag and the evicted key.
// The cfg_ channel writes the capacity (entries before eviction starts);
// it is always ready and should only be written while no request is open.
// A request accepted into the request register is answered from there: its
// response is loaded into the output register once that register is free or being read.
// Throughput: one request per cycle while the receiver does not stall; all slots compare their key and update
// their recency rank in the same cycle, so the next request sees the result.
// When the receiver stalls, the response is held and one more request is
// taken into the request register; s_tready then drops until m_tready.
// Reset clears all valid bits, ranks and the occupancy count and sets the
// capacity to 16.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lrukv_pkg::S_TDATA_W-1:0]   s_tdata,  // key[31:0], value[62:32], zero pad
    input  logic                              s_tuser,  // req_type
    // response stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lrukv_pkg::M_TDATA_W-1:0]   m_tdata,  // hit, read_value, evicted,
                                                        // evicted_key, zero pad
    // capacity write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrukv_pkg::CFG_W-1:0]       cfg_data
);

    localparam int REC_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lrukv_pkg::CFG_W) ? OCC_W : lrukv_pkg::CFG_W;
    localparam int KW = lrukv_pkg::KEY_W;
    localparam int VW = lrukv_pkg::VAL_W;

    // request register
    logic          in_valid_reg;
    logic          in_type_reg;
    logic [KW-1:0] in_key_reg;
    logic [VW-1:0] in_val_reg;

    // response register
    logic          m_valid_reg;
    logic          out_hit_reg, out_hit_next;
    logic [VW-1:0] out_rd_reg, out_rd_next;
    logic          out_ev_reg, out_ev_next;
    logic [KW-1:0] out_evk_reg, out_evk_next;

    // control state
    logic [lrukv_pkg::CFG_W-1:0] cap_reg;
    logic [OCC_W-1:0]            occ_reg, occ_next;

    // slot array view
    logic [MAX_ENTRIES-1:0] slot_valid;
    logic [MAX_ENTRIES-1:0] slot_match;
    logic [KW-1:0]          slot_key   [MAX_ENTRIES];
    logic [VW-1:0]          slot_value [MAX_ENTRIES];
    logic [REC_W-1:0]       slot_rank  [MAX_ENTRIES];
    lrukv_pkg::slot_op_t    slot_op    [MAX_ENTRIES];
    lrukv_pkg::age_cmd_t    age_cmd;

    logic                   advance;
    logic                   hit_any;
    logic [REC_W-1:0]       hit_rank;
    logic [VW-1:0]          hit_value;
    logic [KW-1:0]          evict_key;
    logic [MAX_ENTRIES-1:0] evict_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] target_vec;
    logic [REC_W-1:0]       oldest_rank;
    logic [CMP_W-1:0]       cap_eff;
    logic                   full;
    logic                   set_miss;

    // handshakes
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // request register load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_key_reg  <= s_tdata[KW-1:0];
            in_val_reg  <= s_tdata[KW+VW-1:KW];
        end
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lrukv_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // slot array
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_slot
        lrukv_slot #(
            .REC_W (REC_W)
        ) u_slot (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (slot_op[i]),
            .age      (age_cmd),
            .hit_rank (hit_rank),
            .key_in   (in_key_reg),
            .value_in (in_val_reg),
            .valid    (slot_valid[i]),
            .match    (slot_match[i]),
            .key      (slot_key[i]),
            .value    (slot_value[i]),
            .rank     (slot_rank[i])
        );
    end

    // hit lookup: keys are unique among valid slots, so at most one bit of the match vector is set
    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_rank  = hit_rank  | (slot_match[i] ? slot_rank[i]  : '0);
            hit_value = hit_value | (slot_match[i] ? slot_value[i] : '0);
        end
    end
    assign hit_any = |slot_match;

    // effective capacity clamped to one..MAX_ENTRIES
    always_comb begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
    end
    assign full = CMP_W'(occ_reg) >= cap_eff;

    // victim is the slot holding the largest rank, occupancy minus one
    assign oldest_rank = REC_W'(occ_reg - 1'b1);
    always_comb begin
        evict_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            evict_vec[i] = slot_valid[i] && (slot_rank[i] == oldest_rank);
            evict_key    = evict_key | (evict_vec[i] ? slot_key[i] : '0);
        end
    end

    // lowest free slot: isolate the lowest set bit of the invalid mask
    assign free_vec   = ~slot_valid & (slot_valid + 1'b1);
    assign target_vec = full ? evict_vec : free_vec;

    // slot commands
    assign set_miss        = advance && (in_type_reg == lrukv_pkg::REQ_SET) && !hit_any;
    assign age_cmd.age_all = set_miss;
    assign age_cmd.age_hit = advance && hit_any;
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_op[i].load        = set_miss && target_vec[i];
            slot_op[i].touch       = advance && slot_match[i];
            slot_op[i].write_value = (in_type_reg == lrukv_pkg::REQ_SET);
        end
    end

    // occupancy grows only on an insertion into a free slot
    always_comb begin
        occ_next = occ_reg;
        if (set_miss && !full) begin
            occ_next = occ_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // response fields
    always_comb begin
        out_hit_next = hit_any;
        out_rd_next  = (hit_any && (in_type_reg == lrukv_pkg::REQ_GET)) ? hit_value : '0;
        out_ev_next  = (in_type_reg == lrukv_pkg::REQ_SET) && !hit_any && full;
        out_evk_next = out_ev_next ? evict_key : '0;
    end

    // response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_hit_reg <= out_hit_next;
            out_rd_reg  <= out_rd_next;
            out_ev_reg  <= out_ev_next;
            out_evk_reg <= out_evk_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lrukv_pkg::M_TDATA_W - lrukv_pkg::M_USED_W){1'b0}},
                       out_evk_reg, out_ev_reg, out_rd_reg, out_hit_reg};

endmodule

// ===== rtl/lrukv_checker.sv =====
// port-level checks on the lru key-value cache response stream, bound to the top level
module lrukv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lrukv_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                          rsp_hit;
    logic                          rsp_ev;
    logic [lrukv_pkg::VAL_W-1:0]   rsp_rd;
    logic [lrukv_pkg::KEY_W-1:0]   rsp_evk;

    // response field unpack
    assign rsp_hit = m_tdata[lrukv_pkg::M_HIT_LSB];
    assign rsp_rd  = m_tdata[lrukv_pkg::M_RD_LSB +: lrukv_pkg::VAL_W];
    assign rsp_ev  = m_tdata[lrukv_pkg::M_EV_LSB];
    assign rsp_evk = m_tdata[lrukv_pkg::M_EVK_LSB +: lrukv_pkg::KEY_W];

    // no response right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("response valid after reset");

    // a stalled response holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response changed while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(rsp_hit && rsp_ev))
        else $error("hit and eviction in one response");

    // evicted key is zero without an eviction
    a_evk_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !rsp_ev |-> rsp_evk == '0)
        else $error("evicted key set without eviction");

    // a read value only comes with a hit
    a_rd_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (rsp_rd != '0) |-> rsp_hit)
        else $error("read value without hit");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/lru_key_value_cache_tb.sv =====
// self-checking testbench for the lru key-value cache
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

    localparam int  KEY_W       = lrukv_pkg::KEY_W;
    localparam int  VAL_W       = lrukv_pkg::VAL_W;
    localparam int  CFG_W       = lrukv_pkg::CFG_W;
    localparam int  S_TDATA_W   = lrukv_pkg::S_TDATA_W;
    localparam int  M_TDATA_W   = lrukv_pkg::M_TDATA_W;
    localparam int  SLOTS       = 16;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  PHASE_ITEMS = 80;
    localparam int  POOL_SIZE   = 40;

    // one response as the cache reports it
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_resp_t;

    // one line of the directed table: a capacity write or a request
    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cap;
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        bit               typed;
        cache_resp_t      resp;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // key[31:0], value[62:32], zero pad
    logic                 s_tuser;  // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;  // hit, read_value, evicted, evicted_key, zero pad
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    // shadow copy of the cache contents
    logic                 shadow_valid [SLOTS];
    logic [KEY_W-1:0]     shadow_key   [SLOTS];
    logic [VAL_W-1:0]     shadow_value [SLOTS];
    int                   shadow_rank  [SLOTS];
    int                   shadow_count;
    logic [CFG_W-1:0]     shadow_cap;

    cache_resp_t          pending_resp [$];
    dir_row_t             dir_rows [$];
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];

    int  err_count = 0;
    int  cycle_count = 0;
    int  burst_left;
    int  n_gets, n_sets, n_hits, n_evicts, n_cfg;
    int  n_resp = 0;
    int  stall_mode = 0;
    int  stall_tick = 0;

    lru_key_value_cache u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_resp.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure in one of four randomly picked stall modes
    always @(negedge aclk) begin
        stall_tick++;
        if (stall_tick % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        if (!aresetn) begin
            m_tready = 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = (stall_tick % 4 == 0);
                default: m_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // mismatch report
    task automatic report_mismatch(string msg);
        err_count++;
        $display("mismatch at cycle %0d: %0s", cycle_count, msg);
    endtask

    // response checker
    always @(posedge aclk) begin
        cache_resp_t want;
        cache_resp_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit         = m_tdata[lrukv_pkg::M_HIT_LSB];
            got.read_value  = m_tdata[lrukv_pkg::M_RD_LSB +: VAL_W];
            got.evicted     = m_tdata[lrukv_pkg::M_EV_LSB];
            got.evicted_key = m_tdata[lrukv_pkg::M_EVK_LSB +: KEY_W];
            n_resp++;
            if (pending_resp.size() == 0) begin
                report_mismatch("response with no request open");
            end else begin
                want = pending_resp.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("hit got 0x%0h expected 0x%0h",
                                              got.hit, want.hit));
                if (got.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got 0x%0h expected 0x%0h",
                                              got.read_value, want.read_value));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted got 0x%0h expected 0x%0h",
                                              got.evicted, want.evicted));
                if (got.evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key got 0x%0h expected 0x%0h",
                                              got.evicted_key, want.evicted_key));
            end
        end
    end

    // lookup and lru update for one request, returns the expected response
    function automatic cache_resp_t predict_access(logic kind, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] val);
        cache_resp_t r;
        int found;
        int target;
        int oldest;
        int eff_cap;
        int old_rank;
        r = '0;
        found = -1;
        target = -1;
        oldest = 0;
        eff_cap = (shadow_cap < 1) ? 1 : (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_key[i] == key) begin
                found = i;
                break;
            end
        end
        if (found >= 0) begin
            // hit: newer entries age, this one becomes most recent
            r.hit = 1'b1;
            if (kind == lrukv_pkg::REQ_SET)
                shadow_value[found] = val;
            else
                r.read_value = shadow_value[found];
            old_rank = shadow_rank[found];
            for (int i = 0; i < SLOTS; i++)
                if (shadow_valid[i] && shadow_rank[i] < old_rank)
                    shadow_rank[i]++;
            shadow_rank[found] = 0;
        end else if (kind == lrukv_pkg::REQ_SET) begin
            // full: evict the oldest, its slot takes the new pair
            if (shadow_count >= eff_cap) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i] && (target < 0 || shadow_rank[i] > oldest)) begin
                        target = i;
                        oldest = shadow_rank[i];
                    end
                end
                if (target >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = shadow_key[target];
                    shadow_valid[target] = 1'b0;
                    shadow_count--;
                end
            end
            // otherwise the lowest free slot
            if (target < 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!shadow_valid[i]) begin
                        target = i;
                        break;
                    end
                end
            end
            if (target >= 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_valid[i])
                        shadow_rank[i]++;
                shadow_valid[target] = 1'b1;
                shadow_key[target] = key;
                shadow_value[target] = val;
                shadow_rank[target] = 0;
                shadow_count++;
            end
        end
        return r;
    endfunction

    // table row builders
    function automatic dir_row_t row_req(logic kind, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] val);
        dir_row_t d;
        d = '{is_cfg: 1'b0, cap: '0, kind: kind, key: key, val: val,
              typed: 1'b0, resp: '0};
        return d;
    endfunction

    function automatic dir_row_t row_chk(logic kind, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] val, logic hit,
                                         logic [VAL_W-1:0] rd, logic ev,
                                         logic [KEY_W-1:0] evk);
        dir_row_t d;
        d = row_req(kind, key, val);
        d.typed = 1'b1;
        d.resp = '{hit: hit, read_value: rd, evicted: ev, evicted_key: evk};
        return d;
    endfunction

    function automatic dir_row_t row_cfg(logic [CFG_W-1:0] cap);
        dir_row_t d;
        d = row_req(lrukv_pkg::REQ_GET, '0, '0);
        d.is_cfg = 1'b1;
        d.cap = cap;
        return d;
    endfunction

    // send one request in bursts with random gaps, record its expected response
    task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                                bit typed, cache_resp_t typed_resp);
        cache_resp_t pred;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata  = {$urandom, $urandom};
                s_tuser  = 1'($urandom_range(0, 1));
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, val, key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = predict_access(kind, key, val);
        pending_resp.push_back(typed ? typed_resp : pred);
        if (kind == lrukv_pkg::REQ_SET) n_sets++; else n_gets++;
        if (pred.hit) n_hits++;
        if (pred.evicted) n_evicts++;
        burst_left--;
    endtask

    // stop sending and wait until every response is back
    task automatic drain_requests();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_resp.size() != 0)
            @(posedge aclk);
        burst_left = 0;
    endtask

    // capacity write while the cache is idle
    task automatic write_capacity(logic [CFG_W-1:0] cap);
        drain_requests();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = cap;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        shadow_cap = cap;
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random key: mostly from a pool sized around the capacity so hits occur
    function automatic logic [KEY_W-1:0] pick_key();
        int eff_cap;
        eff_cap = (shadow_cap < 1) ? 1 : (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        return key_pool[$urandom_range(0, eff_cap + 3)];
    endfunction

    // main sequence
    initial begin
        logic [CFG_W-1:0] phase_caps [10];
        logic [VAL_W-1:0] val;
        int pick;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = lrukv_pkg::REQ_GET;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 0;
        n_gets = 0; n_sets = 0; n_hits = 0; n_evicts = 0; n_cfg = 0;

        // state after reset
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_count = 0;
        shadow_cap   = lrukv_pkg::CAP_RESET;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extreme keys and values, set hit, get miss, clamped and
        // lowered capacity, eviction order
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'h0000_0000, 31'h0,
                                   0, 31'h0, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_SET, 32'h0000_0000, 31'h0,
                                   0, 31'h0, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'h0000_0000, 31'h0,
                                   1, 31'h0, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_SET, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                                   0, 31'h0, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'hFFFF_FFFF, 31'h0,
                                   1, 31'h7FFF_FFFF, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_SET, 32'h0000_0000, 31'h7FFF_FFFF,
                                   1, 31'h0, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'h0000_0000, 31'h1234,
                                   1, 31'h7FFF_FFFF, 0, 32'h0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'h0000_1234, 31'h7FFF_FFFF,
                                   0, 31'h0, 0, 32'h0));
        // zero acts as one, below the two entries held
        dir_rows.push_back(row_cfg(5'd0));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_SET, 32'hA5A5_A5A5, 31'h2AAA_AAAA,
                                   0, 31'h0, 1, 32'hFFFF_FFFF));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_SET, 32'h5A5A_5A5A, 31'h5555_5555,
                                   0, 31'h0, 1, 32'h0000_0000));
        dir_rows.push_back(row_chk(lrukv_pkg::REQ_GET, 32'hA5A5_A5A5, 31'h0,
                                   1, 31'h2AAA_AAAA, 0, 32'h0));
        // above the slot count acts as the slot count
        dir_rows.push_back(row_cfg(5'd31));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_SET, 32'h0000_0001, 31'h1));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_SET, 32'h0000_0002, 31'h2));
        dir_rows.push_back(row_cfg(5'd1));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_SET, 32'h0000_0003, 31'h3));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_GET, 32'h0000_0003, 31'h0));
        dir_rows.push_back(row_cfg(5'd2));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_SET, 32'h8000_0000, 31'h4000_0000));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_GET, 32'h5A5A_5A5A, 31'h0));
        dir_rows.push_back(row_req(lrukv_pkg::REQ_GET, 32'h0000_0001, 31'h0));
        dir_rows.push_back(row_cfg(5'd16));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].cap);
            else
                send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].val,
                             dir_rows[i].typed, dir_rows[i].resp);
        end

        // random phases, each under its own capacity
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd2, 5'd12, 5'd20, 5'd3, 5'd16};
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                val = (pick == 0) ? '0 : (pick == 1) ? '1 : VAL_W'($urandom);
                send_request(1'($urandom_range(0, 1)), pick_key(), val, 1'b0, '0);
            end
        end

        drain_requests();
        repeat (5) @(posedge aclk);

        $display("%0d gets, %0d sets, %0d hits, %0d evictions, %0d responses checked",
                 n_gets, n_sets, n_hits, n_evicts, n_resp);
        $display("%0d capacity writes including 0, 1, 16 and 31, %0d mismatches",
                 n_cfg, err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== lru_key_value_cache.f =====
rtl/lrukv_pkg.sv
rtl/lrukv_slot.sv
rtl/lru_key_value_cache.sv
rtl/lrukv_checker.sv
bench/lru_key_value_cache_tb.sv
